/* rtl/assert_macros.svh */
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define SPO2R_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define SPO2R_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/spo2r_pkg.sv */
// types and constants of the spo2 and pulse rate unit
`default_nettype none

package spo2r_pkg;

  // field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned DcW     = 16;
  localparam int unsigned RatioW  = 16;
  localparam int unsigned RateW   = 16;
  localparam int unsigned Spo2W   = 7;
  localparam int unsigned CoefW   = 7;
  localparam int unsigned MulW    = 16;
  localparam int unsigned ProdW   = 2 * MulW;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  // shared divider sizes: dividend, divisor, quotient
  localparam int unsigned DivNumW = 44;
  localparam int unsigned DivDenW = 32;
  localparam int unsigned QuoW    = 16;

  typedef logic signed [SampleW-1:0] sample_t;

  // peak start values
  localparam sample_t PeakStart = sample_t'(700);

  // ratio of one in q4.12
  localparam logic [RatioW-1:0] RatioOne = RatioW'(4096);
  localparam logic [RatioW-1:0] RatioMax = '1;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgLowIntercept  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLowSlope      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHighIntercept = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgHighSlope     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRateScale     = 3'd4;

  // register reset values
  localparam logic [CoefW-1:0] LowInterceptRst  = 7'd110;
  localparam logic [CoefW-1:0] LowSlopeRst      = 7'd25;
  localparam logic [CoefW-1:0] HighInterceptRst = 7'd120;
  localparam logic [CoefW-1:0] HighSlopeRst     = 7'd35;
  localparam logic [RateW-1:0] RateScaleRst     = 16'd15000;

  typedef enum logic [1:0] {
    DirFall    = 2'd0,
    DirRise    = 2'd1,
    DirUnknown = 2'd2
  } dir_e;

  typedef enum logic [3:0] {
    StIdle,
    StMulA,
    StMulB,
    StRatio,
    StDivR,
    StMulS,
    StSpo2,
    StDivP,
    StDone
  } state_e;

  typedef struct packed {
    sample_t          red_ac;
    sample_t          ir_ac;
    logic [DcW-1:0]   red_dc;
    logic [DcW-1:0]   ir_dc;
  } in_t;

  typedef struct packed {
    logic [Spo2W-1:0] spo2;
    logic [RateW-1:0] pulse_rate;
    logic             ratio_valid;
    logic             rate_valid;
  } out_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [QuoW-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/pulse_oximeter_spo2_rate_unit.sv */
// top level of the spo2 and pulse rate unit
//
// Input channel in_valid_i / in_stall_o carries one sample (red and
// infrared ac and dc). Output channel out_valid_o / out_stall_i gives one
// result per sample: spo2, pulse rate and two valid flags. A transaction
// happens at a clock edge with valid high and stall low.
// Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i),
// to be written by the user only while the unit is idle; the unit does not
// enforce this. Unknown indexes are ignored. After a sample is accepted, the
// sequencer runs two multiplies on a shared 16x16 multiplier, the ratio
// division, the slope multiply, then the rate division; it takes the next
// sample only when back in idle after the result is loaded. Each division
// holds the sequencer for its 16 compare and subtract steps and its done
// strobe; a zero or saturated ratio, or a zero mean half-period, skips its
// division. in_stall_o is high while a sample is in work.
// The result sits in an output register; the next sample is taken while it
// waits. If the receiver stalls and the register is still full when a new
// result is done, the sequencer holds that result until the register frees.
// Reset (rst_ni low, asynchronous) restores register defaults and peak start
// values, clears directions, indexes, half-periods and the output register.
`default_nettype none
`include "assert_macros.svh"

module pulse_oximeter_spo2_rate_unit import spo2r_pkg::*; #(
  parameter int unsigned INDEX_WIDTH = 24
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire in_t                in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_t                    out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i
);

  state_e state_q, state_d;

  logic [CoefW-1:0] low_icpt_q, low_slope_q, high_icpt_q, high_slope_q;
  logic [RateW-1:0] rate_scale_q;

  logic [INDEX_WIDTH-1:0] index_q;
  logic [DcW-1:0]         red_dc_q, ir_dc_q;
  logic [ProdW-1:0]       num_q, den_q;
  logic [RatioW-1:0]      r_q;
  logic                   ratio_ok_q;
  logic [Spo2W-1:0]       spo2_q;
  logic [RateW-1:0]       rate_q;
  logic                   rate_ok_q;
  out_t                   out_q;
  logic                   out_valid_q;

  logic                   in_accept;
  logic                   out_load;
  logic [SampleW-1:0]     ptp_red, ptp_ir;
  logic [INDEX_WIDTH-1:0] hp_red, hp_ir;
  logic [INDEX_WIDTH:0]   hp_sum;
  logic [INDEX_WIDTH-1:0] mean;
  logic                   mean_zero;
  logic                   ratio_zero;
  logic                   ratio_sat;
  logic                   low_line;
  logic [MulW-1:0]        mul_a, mul_b;
  logic [ProdW-1:0]       mul_y;
  logic signed [23:0]     line_v;
  logic [23:0]            line_rnd;
  logic [Spo2W-1:0]       spo2_val;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  assign in_accept = in_valid_i && !in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_icpt_q   <= LowInterceptRst;
      low_slope_q  <= LowSlopeRst;
      high_icpt_q  <= HighInterceptRst;
      high_slope_q <= HighSlopeRst;
      rate_scale_q <= RateScaleRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgLowIntercept:  low_icpt_q   <= cfg_wdata_i[CoefW-1:0];
        CfgLowSlope:      low_slope_q  <= cfg_wdata_i[CoefW-1:0];
        CfgHighIntercept: high_icpt_q  <= cfg_wdata_i[CoefW-1:0];
        CfgHighSlope:     high_slope_q <= cfg_wdata_i[CoefW-1:0];
        CfgRateScale:     rate_scale_q <= cfg_wdata_i[RateW-1:0];
        default: ;
      endcase
    end
  end

  // per channel trackers
  spo2r_track #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_track_red (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (in_accept),
    .cur_i         (in_data_i.red_ac),
    .index_i       (index_q),
    .ptp_o         (ptp_red),
    .half_period_o (hp_red)
  );

  spo2r_track #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_track_ir (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (in_accept),
    .cur_i         (in_data_i.ir_ac),
    .index_i       (index_q),
    .ptp_o         (ptp_ir),
    .half_period_o (hp_ir)
  );

  // sample index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_q <= '0;
    end else if (in_accept) begin
      index_q <= index_q + 1'b1;
    end
  end

  // decisions taken by the sequencer
  assign hp_sum     = {1'b0, hp_red} + {1'b0, hp_ir};
  assign mean       = hp_sum[INDEX_WIDTH:1];
  assign mean_zero  = (mean == '0);
  assign ratio_zero = (den_q == '0) || (ir_dc_q == '0);
  assign ratio_sat  = ({4'b0, num_q} >= {den_q, 4'b0});
  assign low_line   = (r_q <= RatioOne);

  // shared multiplier
  assign mul_y = mul_a * mul_b;

  // spo2 line, rounded half away from zero and clamped at zero
  always_comb begin
    line_v = $signed({5'b0, (low_line ? low_icpt_q : high_icpt_q), 12'b0})
           - $signed({1'b0, num_q[22:0]});
    line_rnd = 24'(line_v) + 24'd2048;
    spo2_val = (line_v <= 0) ? '0 : line_rnd[12 +: Spo2W];
  end

  // shared divider
  spo2r_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_valid_i) state_d = StMulA;
      StMulA:  state_d = StMulB;
      StMulB:  state_d = StRatio;
      StRatio: state_d = (ratio_zero || ratio_sat) ? StMulS : StDivR;
      StDivR:  if (div_rsp.done) state_d = StMulS;
      StMulS:  state_d = StSpo2;
      StSpo2:  state_d = mean_zero ? StDone : StDivP;
      StDivP:  if (div_rsp.done) state_d = StDone;
      StDone:  if (!out_valid_q || !out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o  = 1'b1;
    out_load    = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
      end
      StMulA: begin
        mul_a = MulW'(ptp_red);
        mul_b = MulW'(ir_dc_q);
      end
      StMulB: begin
        mul_a = MulW'(red_dc_q);
        mul_b = MulW'(ptp_ir);
      end
      StRatio: begin
        div_req.start = !(ratio_zero || ratio_sat);
        div_req.num   = {num_q, 12'b0};
        div_req.den   = den_q;
      end
      StMulS: begin
        mul_a = MulW'(r_q);
        mul_b = MulW'(low_line ? low_slope_q : high_slope_q);
      end
      StSpo2: begin
        div_req.start = !mean_zero;
        div_req.num   = DivNumW'(rate_scale_q);
        div_req.den   = DivDenW'(mean);
      end
      StDone: begin
        out_load = !out_valid_q || !out_stall_i;
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_accept) begin
          red_dc_q <= in_data_i.red_dc;
          ir_dc_q  <= in_data_i.ir_dc;
        end
      end
      StMulA: num_q <= mul_y;
      StMulB: den_q <= mul_y;
      StRatio: begin
        ratio_ok_q <= !ratio_zero;
        if (ratio_zero) begin
          r_q <= '0;
        end else if (ratio_sat) begin
          r_q <= RatioMax;
        end
      end
      StDivR: if (div_rsp.done) r_q <= div_rsp.quo;
      StMulS: num_q <= mul_y;
      StSpo2: begin
        spo2_q    <= spo2_val;
        rate_ok_q <= !mean_zero;
        if (mean_zero) rate_q <= '0;
      end
      StDivP: if (div_rsp.done) rate_q <= div_rsp.quo;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.spo2        <= spo2_q;
      out_q.pulse_rate  <= rate_q;
      out_q.ratio_valid <= ratio_ok_q;
      out_q.rate_valid  <= rate_ok_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `SPO2R_ASSERT(a_accept_starts, in_accept |=> state_q == StMulA, "sample not started")
  `SPO2R_ASSERT(a_div_done_waited, div_rsp.done |-> (state_q == StDivR || state_q == StDivP), "divider done while not waited on")
  `SPO2R_ASSERT(a_load_from_done, $rose(out_valid_q) |-> $past(state_q) == StDone, "result loaded outside done state")
  `SPO2R_ASSERT_ALWAYS(a_stall_when_busy, (state_q != StIdle) |-> in_stall_o, "input taken while busy")

endmodule

`default_nettype wire

/* rtl/spo2r_track.sv */
// peak, valley and half-period tracker for one channel
`default_nettype none

module spo2r_track import spo2r_pkg::*; #(
  parameter int unsigned INDEX_WIDTH = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire sample_t                cur_i,
  input  wire logic [INDEX_WIDTH-1:0] index_i,
  output logic [SampleW-1:0]          ptp_o,
  output logic [INDEX_WIDTH-1:0]      half_period_o
);

  sample_t                prev_q, prev_d;
  sample_t                high_q, high_d;
  sample_t                low_q, low_d;
  dir_e                   dir_q, dir_d, dir_mid;
  logic [INDEX_WIDTH-1:0] hidx_q, hidx_d;
  logic [INDEX_WIDTH-1:0] hp_q, hp_d;
  logic signed [SampleW:0] diff;

  // valley test first, then peak test with the updated direction
  always_comb begin
    prev_d  = cur_i;
    high_d  = high_q;
    low_d   = low_q;
    hidx_d  = hidx_q;
    hp_d    = hp_q;
    dir_mid = dir_q;
    if (dir_q == DirFall && cur_i > prev_q) begin
      low_d   = prev_q;
      dir_mid = DirRise;
      hp_d    = index_i - hidx_q;
    end
    dir_d = dir_mid;
    if (dir_mid != DirFall && cur_i < prev_q) begin
      high_d = prev_q;
      hidx_d = index_i;
      dir_d  = DirFall;
    end
  end

  // channel state, updated once per accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      high_q <= PeakStart;
      low_q  <= -PeakStart;
      hidx_q <= '0;
      hp_q   <= '0;
      dir_q  <= DirUnknown;
    end else if (en_i) begin
      prev_q <= prev_d;
      high_q <= high_d;
      low_q  <= low_d;
      hidx_q <= hidx_d;
      hp_q   <= hp_d;
      dir_q  <= dir_d;
    end
  end

  // peak to peak magnitude
  assign diff  = {high_q[SampleW-1], high_q} - {low_q[SampleW-1], low_q};
  assign ptp_o = diff[SampleW] ? SampleW'(-diff) : diff[SampleW-1:0];

  assign half_period_o = hp_q;

endmodule

`default_nettype wire

/* rtl/spo2r_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none

module spo2r_div import spo2r_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  // dividend high part must be below the divisor, so the quotient fits
  localparam int unsigned CntW = $clog2(QuoW + 1);

  logic [DivDenW-1:0] rem_q, rem_d;
  logic [QuoW-1:0]    low_q, low_d;
  logic [DivDenW-1:0] den_q;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [DivDenW:0]   trial;
  logic [DivDenW:0]   diff;
  logic               take;

  // one compare and subtract step
  always_comb begin
    trial = {rem_q, low_q[QuoW-1]};
    diff  = trial - {1'b0, den_q};
    take  = (trial >= {1'b0, den_q});
    rem_d = take ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
    low_d = {low_q[QuoW-2:0], take};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(QuoW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands and partial remainder
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= DivDenW'(req_i.num[DivNumW-1:QuoW]);
      low_q <= req_i.num[QuoW-1:0];
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = low_q;

endmodule

`default_nettype wire
